// ===== src/ajt_pkg.sv =====
// Package with shared types, constants and command structs of the alarm job table.
`timescale 1ns / 1ps
package ajt_pkg;

  localparam int MaxJobsDefault = 16;
  localparam logic [16:0] DaySec = 17'(24 * 3600);
  localparam logic [26:0] IdleMs = 27'd5000;

  localparam logic [1:0] ModeCheck  = 2'd0;
  localparam logic [1:0] ModeAdd    = 2'd1;
  localparam logic [1:0] ModeRemove = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [39:0] now;
    logic [31:0] job_id;
    logic        periodic;
    logic [31:0] interval_sec;
    logic [39:0] at_time;
    logic        delete_after_run;
  } in_item_t;

  typedef struct packed {
    logic        result_type;
    logic [31:0] fired_id;
    logic        accepted;
    logic        timer_running;
    logic [26:0] next_check_ms;
    logic [4:0]  jobs_held;
    logic        last;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture the input item
    logic scan_start; // reset scan pointers
    logic check_step; // examine slot rd, fire / keep
    logic rem_step;   // examine slot rd for a remove match
    logic add_write;  // append the captured job
    logic sched_step; // fold slot rd into the earliest due time
    logic sched_done; // form the delay from the earliest due time
    logic fin_total;  // job total takes the write pointer
    logic set_acc;    // mark the item accepted
  } ajt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_end;  // read pointer reached the job total
    logic fire;      // slot under the pointer is due
    logic id_match;  // slot under the pointer matches the id
    logic add_ok;    // captured add passes validation
    logic now_zero;
    logic table_empty;
  } ajt_stat_t;

endpackage

// ===== src/ajt_ctrl.sv =====
// Controller state machine sequencing the scans of the alarm job table.
`timescale 1ns / 1ps
module ajt_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_mode,
  input  ajt_pkg::ajt_stat_t stat,
  input  logic              out_free,
  output ajt_pkg::ajt_cmd_t  cmd,
  output logic              emit_fire,
  output logic              emit_sum
);
  import ajt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_FIRE_OUT, S_REMOVE, S_COMPACT, S_ADD, S_SCHED, S_DELAY, S_SUM
  } state_t;

  state_t state;
  logic [1:0] mode;

  assign in_stall = (state != S_IDLE);

  // Command decode from the present state.
  always_comb begin
    cmd = '0;
    emit_fire = 1'b0;
    emit_sum = 1'b0;
    unique case (state)
      S_IDLE:     begin
        cmd.load = in_valid;
        cmd.scan_start = in_valid;
      end
      S_CHECK:    cmd.check_step = !stat.scan_end && !stat.fire;
      S_FIRE_OUT: begin
        emit_fire = out_free;
        cmd.check_step = out_free;
      end
      S_REMOVE:   cmd.rem_step = !stat.scan_end;
      S_COMPACT:  begin
        cmd.fin_total = 1'b1;
        cmd.scan_start = 1'b1;
      end
      S_ADD:      begin
        cmd.add_write = stat.add_ok;
        cmd.set_acc = stat.add_ok;
        cmd.scan_start = 1'b1;
      end
      S_SCHED:    cmd.sched_step = !stat.scan_end;
      S_DELAY:    cmd.sched_done = 1'b1;
      S_SUM:      emit_sum = out_free;
      default:    ;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      mode <= ModeCheck;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid) begin
          mode <= in_mode;
          priority if (in_mode == ModeCheck) state <= S_CHECK;
          else if (in_mode == ModeAdd) state <= S_ADD;
          else if (in_mode == ModeRemove) state <= S_REMOVE;
          else state <= S_SCHED;
        end
        S_CHECK: begin
          priority if (stat.now_zero) state <= S_SUM;
          else if (stat.scan_end) state <= S_COMPACT;
          else if (stat.fire) state <= S_FIRE_OUT;
        end
        S_FIRE_OUT: if (out_free) state <= S_CHECK;
        S_REMOVE:  if (stat.scan_end) state <= S_COMPACT;
        S_COMPACT: state <= S_SCHED;
        S_ADD:     state <= S_SCHED;
        S_SCHED:   if (stat.scan_end) state <= S_DELAY;
        S_DELAY:   state <= S_SUM;
        S_SUM:     if (out_free) state <= S_IDLE;
        default:   state <= S_IDLE;
      endcase
    end
  end

  logic unused_mode;
  assign unused_mode = ^mode;
endmodule

// ===== src/ajt_dp.sv =====
// Datapath of the alarm job table: slot memories, scan pointers and the due-time search.
`timescale 1ns / 1ps
module ajt_dp #(
  parameter int MAX_JOBS = ajt_pkg::MaxJobsDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  ajt_pkg::in_item_t  in_item,
  input  ajt_pkg::ajt_cmd_t  cmd,
  input  logic               emit_fire,
  input  logic               emit_sum,
  output ajt_pkg::ajt_stat_t stat,
  output ajt_pkg::out_item_t res
);
  import ajt_pkg::*;

  localparam int IW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int CW = $clog2(MAX_JOBS + 1);

  // Slot store: one flop array per field, read through the scan pointer.
  logic [31:0] s_id [MAX_JOBS];
  logic        s_per [MAX_JOBS];
  logic [31:0] s_ivl [MAX_JOBS];
  logic [39:0] s_at [MAX_JOBS];
  logic [39:0] s_last [MAX_JOBS];
  logic [40:0] s_next [MAX_JOBS];
  logic        s_drop [MAX_JOBS];

  in_item_t    item;
  logic [CW-1:0] total, rd, wr;
  logic        acc, removed;
  logic [40:0] earliest;
  logic [26:0] delay_ms;

  logic [IW-1:0] ri, wi, ti;
  assign ri = rd[IW-1:0];
  assign wi = wr[IW-1:0];
  assign ti = total[IW-1:0];

  // Fields of the slot under the read pointer.
  logic [40:0] cur_next, fresh_next, due;
  logic        fire;
  assign fresh_next = 41'(item.now) + 41'(s_ivl[ri]);
  assign cur_next = (s_next[ri] == '0) ? fresh_next : s_next[ri];
  assign fire = s_per[ri] ? ({1'b0, item.now} >= cur_next)
              : ((item.now >= s_at[ri]) && (s_last[ri] == '0));
  assign due = s_per[ri] ? cur_next : ((s_last[ri] == '0) ? {1'b0, s_at[ri]} : '0);

  assign stat.scan_end = (rd >= total);
  assign stat.fire = fire;
  assign stat.id_match = (s_id[ri] == item.job_id);
  assign stat.add_ok = (total < CW'(MAX_JOBS)) && (item.now != '0)
                     && !(item.periodic && item.interval_sec == '0)
                     && !(!item.periodic && item.at_time == '0);
  assign stat.now_zero = (item.now == '0);
  assign stat.table_empty = (total == '0);

  // Delay from the earliest due time, clipped to one day.
  logic [40:0] diff;
  logic [16:0] dsec;
  assign diff = earliest - {1'b0, item.now};
  always_comb begin
    if (earliest <= {1'b0, item.now}) dsec = 17'd1;
    else if (diff > 41'(DaySec)) dsec = DaySec;
    else dsec = diff[16:0];
  end

  // Slot writes: close-up copy to the write pointer, append at the job total and in-place update.
  logic keep_cur;
  assign keep_cur = !(fire && s_drop[ri]);
  always_ff @(posedge clk) begin
    if (cmd.check_step && !stat.scan_end) begin
      if (emit_fire) begin
        s_id[wi] <= s_id[ri]; s_per[wi] <= s_per[ri]; s_ivl[wi] <= s_ivl[ri];
        s_at[wi] <= s_at[ri]; s_drop[wi] <= s_drop[ri];
        s_last[wi] <= item.now;
        s_next[wi] <= s_per[ri] ? fresh_next : s_next[ri];
      end else begin
        s_id[wi] <= s_id[ri]; s_per[wi] <= s_per[ri]; s_ivl[wi] <= s_ivl[ri];
        s_at[wi] <= s_at[ri]; s_drop[wi] <= s_drop[ri];
        s_last[wi] <= s_last[ri];
        s_next[wi] <= s_per[ri] ? cur_next : s_next[ri];
      end
    end else if (cmd.rem_step) begin
      s_id[wi] <= s_id[ri]; s_per[wi] <= s_per[ri]; s_ivl[wi] <= s_ivl[ri];
      s_at[wi] <= s_at[ri]; s_drop[wi] <= s_drop[ri];
      s_last[wi] <= s_last[ri]; s_next[wi] <= s_next[ri];
    end else if (cmd.add_write) begin
      s_id[ti] <= item.job_id; s_per[ti] <= item.periodic;
      s_ivl[ti] <= item.interval_sec; s_at[ti] <= item.at_time;
      s_drop[ti] <= item.delete_after_run; s_last[ti] <= '0;
      s_next[ti] <= item.periodic ? (41'(item.now) + 41'(item.interval_sec)) : '0;
    end else if (cmd.sched_step && s_per[ri] && s_next[ri] == '0) begin
      s_next[ri] <= fresh_next;
    end
  end

  // Pointers, totals, result register.
  logic rem_hit;
  assign rem_hit = stat.id_match && !removed;
  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
      rd <= '0;
      wr <= '0;
      acc <= 1'b0;
      removed <= 1'b0;
    end else begin
      if (cmd.load) begin
        item <= in_item;
        acc <= (in_item.mode == ModeCheck);
        removed <= 1'b0;
      end
      if (cmd.scan_start) begin
        rd <= '0;
        wr <= '0;
        earliest <= '0;
      end
      if (cmd.check_step && !stat.scan_end) begin
        rd <= rd + 1'b1;
        if (!(emit_fire && !keep_cur)) wr <= wr + 1'b1;
      end
      if (cmd.rem_step) begin
        rd <= rd + 1'b1;
        if (rem_hit) begin
          removed <= 1'b1;
          acc <= 1'b1;
        end else wr <= wr + 1'b1;
      end
      if (cmd.add_write) total <= total + 1'b1;
      if (cmd.set_acc) acc <= 1'b1;
      if (cmd.fin_total) total <= wr;
      if (cmd.sched_step) begin
        rd <= rd + 1'b1;
        if (due != '0 && (earliest == '0 || due < earliest)) earliest <= due;
      end
      if (cmd.sched_done) begin
        if (total == '0) delay_ms <= '0;
        else if (item.now == '0 || earliest == '0) delay_ms <= IdleMs;
        else delay_ms <= 27'(dsec) * 27'd1000;
      end
    end
  end

  // Result fields.
  always_comb begin
    res = '0;
    if (emit_fire) begin
      res.fired_id = s_id[ri];
    end else begin
      res.result_type = 1'b1;
      res.accepted = acc;
      res.timer_running = (total != '0) || (item.mode == ModeCheck && item.now == '0);
      res.next_check_ms = (item.mode == ModeCheck && item.now == '0) ? IdleMs : delay_ms;
      res.jobs_held = 5'(total);
      res.last = 1'b1;
    end
  end

  logic unused_sum;
  assign unused_sum = emit_sum;
endmodule

// ===== src/alarm_job_table.sv =====
// Top level of the alarm job table: controller, datapath and output register.
`timescale 1ns / 1ps
// Usage:
//   The in channel takes one item (check, add or remove) per valid/stall
//   handshake. Each item yields zero or more fired-job items on the out
//   channel followed by one summary item with last set.
//   The block works on one item at a time; in_stall is high from acceptance
//   until the summary has been loaded into the output register, and the next
//   item can be accepted on the following cycle.
//   A check or remove scans the table, closing it up, then scans it again for
//   the earliest due time before forming the delay and the summary; an add
//   appends the job and goes straight to the due-time scan; a check with the
//   clock unset goes straight to the summary. The slot scans read one slot per
//   cycle, but a check waits for the out channel to take each fired job.
//   Reset clears the job count; slot contents are don't-care until written.
//   A stall on the out channel holds the output register and the controller
//   waits; the input stays stalled meanwhile.
module alarm_job_table #(
  parameter int MAX_JOBS = ajt_pkg::MaxJobsDefault
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  ajt_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output ajt_pkg::out_item_t out_data
);
  import ajt_pkg::*;

  ajt_cmd_t  cmd;
  ajt_stat_t stat;
  out_item_t res;
  logic emit_fire, emit_sum, out_free;

  assign out_free = !out_valid || !out_stall;

  ajt_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .in_mode(in_data.mode), .stat,
    .out_free, .cmd, .emit_fire, .emit_sum
  );

  ajt_dp #(.MAX_JOBS(MAX_JOBS)) u_dp (
    .clk, .rst, .in_item(in_data), .cmd, .emit_fire, .emit_sum, .stat, .res
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= emit_fire || emit_sum;
      if (emit_fire || emit_sum) out_data <= res;
    end
  end

  a_one_emit: assert property (@(posedge clk) disable iff (rst)
    !(emit_fire && emit_sum)) else $error("fire and summary at once");
  a_busy_no_accept: assert property (@(posedge clk) disable iff (rst)
    (emit_fire || emit_sum) |-> in_stall) else $error("input open while emitting");
  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.last) |-> (out_data.jobs_held <= 5'(MAX_JOBS)))
    else $error("job count out of range");
endmodule

// ===== tb/tb_alarm_job_table.sv =====
// Self-checking testbench of the alarm job table with its own job table predictor.
`timescale 1ns / 1ps
module tb_alarm_job_table;
  import ajt_pkg::*;

  localparam int Jobs = 16;
  localparam int CycleLimit = 400000;
  localparam logic [1:0] ModeUnused = 2'd3;
  localparam logic [40:0] Mask41 = 41'h1FFFFFFFFFF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;

  // Predictor copy of the job table.
  logic [31:0] p_id [Jobs];
  logic        p_per [Jobs];
  logic [31:0] p_ivl [Jobs];
  logic [39:0] p_at [Jobs];
  logic [39:0] p_lastrun [Jobs];
  logic [40:0] p_next [Jobs];
  logic        p_drop [Jobs];
  int          p_total;

  out_item_t expected_results[$];
  int mismatches = 0;
  int results_seen = 0;
  int fired_seen = 0;
  int items_sent = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit [39:0] clock_now = 40'd1000;

  alarm_job_table dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #2 clk = ~clk;

  // Timeout guard.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver stalls at random.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (out_data.result_type == 1'b0) fired_seen++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result %p", out_data);
      end else begin
        want = expected_results.pop_front();
        if (out_data !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected %p, got %p", want, out_data);
        end
      end
    end
  end

  // Close up the table in order, keeping slots marked in keep.
  function automatic void close_up(bit keep[Jobs]);
    int w;
    w = 0;
    for (int i = 0; i < p_total; i++) begin
      if (keep[i]) begin
        p_id[w] = p_id[i]; p_per[w] = p_per[i]; p_ivl[w] = p_ivl[i];
        p_at[w] = p_at[i]; p_lastrun[w] = p_lastrun[i];
        p_next[w] = p_next[i]; p_drop[w] = p_drop[i];
        w++;
      end
    end
    p_total = w;
  endfunction

  // Wake timer delay in ms for the summary; running reports the timer state.
  function automatic logic [26:0] wake_delay_ms(logic [39:0] now, output logic running);
    logic [40:0] earliest, due, delay;
    earliest = '0;
    running = (p_total != 0);
    if (p_total == 0) return '0;
    if (now == 0) return IdleMs;
    for (int i = 0; i < p_total; i++) begin
      if (p_per[i]) begin
        if (p_next[i] == 0) p_next[i] = ({1'b0, now} + p_ivl[i]) & Mask41;
        due = p_next[i];
      end else begin
        due = (p_lastrun[i] == 0) ? {1'b0, p_at[i]} : '0;
      end
      if (due != 0 && (earliest == 0 || due < earliest)) earliest = due;
    end
    if (earliest == 0) return IdleMs;
    delay = (earliest > now) ? earliest - now : 41'd1;
    if (delay > DaySec) delay = DaySec;
    return 27'(delay * 1000);
  endfunction

  // Work out the results of one item and update the predictor table.
  task automatic predict_alarm_item(in_item_t it);
    bit keep[Jobs];
    bit acc, fire;
    logic running;
    logic [26:0] ms;
    out_item_t r;
    acc = 0;
    if (it.mode == ModeCheck && it.now == 0) begin
      r = '{1'b1, 32'd0, 1'b1, 1'b1, IdleMs, 5'(p_total), 1'b1};
      expected_results.push_back(r);
      return;
    end
    if (it.mode == ModeCheck) begin
      acc = 1;
      for (int i = 0; i < p_total; i++) begin
        keep[i] = 1;
        if (p_per[i]) begin
          if (p_next[i] == 0) p_next[i] = ({1'b0, it.now} + p_ivl[i]) & Mask41;
          fire = ({1'b0, it.now} >= p_next[i]);
        end else begin
          fire = (it.now >= p_at[i]) && (p_lastrun[i] == 0);
        end
        if (fire) begin
          r = '{1'b0, p_id[i], 1'b0, 1'b0, 27'd0, 5'd0, 1'b0};
          expected_results.push_back(r);
          p_lastrun[i] = it.now;
          if (p_per[i]) p_next[i] = ({1'b0, it.now} + p_ivl[i]) & Mask41;
          if (p_drop[i]) keep[i] = 0;
        end
      end
      close_up(keep);
    end else if (it.mode == ModeAdd) begin
      acc = (p_total < Jobs) && !(it.periodic && it.interval_sec == 0) &&
            (it.now != 0) && !(!it.periodic && it.at_time == 0);
      if (acc) begin
        p_id[p_total] = it.job_id; p_per[p_total] = it.periodic;
        p_ivl[p_total] = it.interval_sec; p_at[p_total] = it.at_time;
        p_lastrun[p_total] = '0;
        p_next[p_total] = it.periodic ? (({1'b0, it.now} + it.interval_sec) & Mask41) : '0;
        p_drop[p_total] = it.delete_after_run;
        p_total++;
      end
    end else if (it.mode == ModeRemove) begin
      for (int i = 0; i < p_total; i++) keep[i] = 1;
      for (int i = 0; i < p_total; i++) begin
        if (!acc && p_id[i] == it.job_id) begin
          keep[i] = 0;
          acc = 1;
        end
      end
      if (acc) close_up(keep);
    end
    ms = wake_delay_ms(it.now, running);
    r = '{1'b1, 32'd0, acc, running, ms, 5'(p_total), 1'b1};
    expected_results.push_back(r);
  endtask

  // Send one item through the input handshake.
  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    predict_alarm_item(it);
    in_data <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    in_valid <= 1'b0;
    items_sent++;
    @(posedge clk);
  endtask

  function automatic in_item_t make_item(logic [1:0] mode, logic [39:0] now,
      logic [31:0] id, logic per, logic [31:0] ivl, logic [39:0] at, logic drop);
    in_item_t it;
    it = '{mode, now, id, per, ivl, at, drop};
    return it;
  endfunction

  task automatic wait_drained();
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Directed extremes and special cases.
  task automatic test_directed();
    send_item(make_item(ModeCheck, 40'd0, 32'd0, 1'b0, 32'd0, 40'd0, 1'b0));
    send_item(make_item(ModeAdd, 40'd0, 32'd1, 1'b1, 32'd5, 40'd0, 1'b0));
    send_item(make_item(ModeRemove, 40'd0, 32'd1, 1'b0, 32'd0, 40'd0, 1'b0));
    send_item(make_item(ModeCheck, 40'd100, 32'd0, 1'b0, 32'd0, 40'd0, 1'b0));
    send_item(make_item(ModeAdd, 40'd100, 32'd2, 1'b1, 32'd0, 40'd0, 1'b0));
    send_item(make_item(ModeAdd, 40'd100, 32'd3, 1'b0, 32'd9, 40'd0, 1'b0));
    send_item(make_item(ModeAdd, 40'd100, 32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF,
                        40'hFFFFFFFFFF, 1'b1));
    send_item(make_item(ModeAdd, 40'd100, 32'd4, 1'b0, 32'd0, 40'd150, 1'b0));
    send_item(make_item(ModeAdd, 40'd100, 32'd4, 1'b0, 32'd0, 40'd50, 1'b1));
    send_item(make_item(ModeAdd, 40'd100, 32'd5, 1'b1, 32'd10, 40'd0, 1'b0));
    send_item(make_item(ModeCheck, 40'd0, 32'd0, 1'b0, 32'd0, 40'd0, 1'b0));
    send_item(make_item(ModeAdd, 40'd0, 32'd9, 1'b1, 32'd3, 40'd0, 1'b0));
    send_item(make_item(ModeCheck, 40'd200, 32'd0, 1'b0, 32'd0, 40'd0, 1'b0));
    send_item(make_item(ModeCheck, 40'd300, 32'd0, 1'b0, 32'd0, 40'd0, 1'b0));
    send_item(make_item(ModeRemove, 40'd300, 32'd4, 1'b0, 32'd0, 40'd0, 1'b0));
    send_item(make_item(ModeRemove, 40'd300, 32'd77, 1'b0, 32'd0, 40'd0, 1'b0));
    send_item(make_item(ModeUnused, 40'hFFFFFFFFFF, 32'd5, 1'b1, 32'd1, 40'd1, 1'b1));
    for (int k = 0; k < 16; k++)
      send_item(make_item(ModeAdd, 40'd400, 32'(k + 20), 1'b0, 32'd0,
                          40'd500 + k, 1'b0));
    send_item(make_item(ModeCheck, 40'hFFFFFFFFFF, 32'd0, 1'b0, 32'd0, 40'd0, 1'b0));
    // Clear the table out for the random phases.
    while (p_total != 0)
      send_item(make_item(ModeRemove, 40'd500, p_id[0], 1'b0, 32'd0, 40'd0, 1'b0));
  endtask

  // Random items, mostly well formed jobs around a moving clock.
  task automatic test_random(int count);
    in_item_t it;
    int pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      clock_now += $urandom_range(40);
      it = 148'({$urandom, $urandom, $urandom, $urandom, $urandom});
      it.now = clock_now;
      if (pick < 40) begin
        it.mode = ModeAdd;
        it.job_id = $urandom_range(12);
        it.interval_sec = $urandom_range(60);
        it.at_time = clock_now + $urandom_range(80) - 20;
      end else if (pick < 75) begin
        it.mode = ModeCheck;
      end else if (pick < 90) begin
        it.mode = ModeRemove;
        it.job_id = $urandom_range(12);
      end else if (pick < 95) begin
        it.now = ($urandom_range(3) == 0) ? 40'd0 : 40'({$urandom, $urandom});
      end else begin
        it.interval_sec = $urandom;
        it.at_time = 40'({$urandom, $urandom});
        it.job_id = $urandom;
      end
      send_item(it);
    end
  endtask

  initial begin
    p_total = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    send_idle_pct = 8;
    recv_idle_pct = 62;
    test_random(100);
    wait_drained();
    send_idle_pct = 62;
    recv_idle_pct = 8;
    test_random(100);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(80);
    wait_drained();
    repeat (60) @(posedge clk);
    $display("Covered %0d items: checks, adds, removes, unused mode and clock-unset cases.",
             items_sent);
    $display("Saw %0d results, %0d of them fired jobs.", results_seen, fired_seen);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches,
               expected_results.size());
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
